// ===== rtl/fpmp_pkg.sv =====
// Package for the multi-turn position controller: widths, constants, sequencer states.
// No dependencies.
package fpmp_pkg;
  localparam int unsigned COUNTS_PER_TURN_DEF = 1023;
  localparam int unsigned MAX_LAPS_DEF = 7;
  localparam int unsigned DEAD_HIGH = 1018;
  localparam int unsigned DEAD_LOW = 5;
  localparam int unsigned CFG_AW = 3;
  localparam int unsigned CFG_DW = 24;

  typedef enum logic [2:0] {
    REG_PROP   = 3'd0,
    REG_INTEG  = 3'd1,
    REG_DERIV  = 3'd2,
    REG_ALPHA  = 3'd3,
    REG_KEEP   = 3'd4,
    REG_DIN    = 3'd5,
    REG_WHIGH  = 3'd6,
    REG_WLOW   = 3'd7
  } reg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE, ST_POS, ST_FE1, ST_FE2, ST_FE3, ST_D1, ST_D2, ST_D3,
    ST_P, ST_I, ST_DD, ST_OUT
  } state_e;

  typedef enum logic [1:0] {
    WAIT_NONE = 2'd0,
    WAIT_UP   = 2'd1,
    WAIT_DOWN = 2'd2
  } wait_e;
endpackage

// ===== rtl/fpmp_if.sv =====
// Valid/ready channel interfaces for input ticks and drive results.
// Depends on nothing.
interface fpmp_in_if;
  logic              valid;
  logic              ready;
  logic              start_move;
  logic signed [13:0] target;
  logic [9:0]        pot_sample;
  modport source (output valid, start_move, target, pot_sample, input ready);
  modport sink (input valid, start_move, target, pot_sample, output ready);
endinterface

interface fpmp_out_if;
  logic              valid;
  logic              ready;
  logic signed [8:0] motor_drive;
  logic              settled;
  logic              crossing;
  modport source (output valid, motor_drive, settled, crossing, input ready);
  modport sink (input valid, motor_drive, settled, crossing, output ready);
endinterface

// ===== rtl/fpmp_mac.sv =====
// Shared signed multiply-accumulate with 64-bit accumulator.
// Depends on nothing beyond its ports.
module fpmp_mac (
  input  logic               clk_i,
  input  logic               clr_i,
  input  logic               en_i,
  input  logic signed [32:0] a_i,
  input  logic signed [25:0] b_i,
  output logic signed [63:0] acc_o
);
  logic signed [63:0] acc_q, acc_d;
  logic signed [58:0] prod;
  assign prod = a_i * b_i;
  always_comb begin
    acc_d = acc_q;
    if (clr_i) acc_d = '0;
    else if (en_i) acc_d = acc_q + 64'(prod);
  end
  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end
  assign acc_o = acc_q;
endmodule

// ===== rtl/filtered_pid_multiturn_position.sv =====
// Multi-turn PID position controller with filtered error and derivative.
// One tick at a time: the next tick can be taken the cycle after the result
// transaction, and the result may wait on output ready. A dead-zone tick gets its
// result from ST_FE1 and skips the filter and PID steps. The shared 33x26
// multiplier (one product a cycle) serves the filter, derivative and PID terms.
// Reset (async, low) restores default gains and clears filter, lap and handshake state.
module filtered_pid_multiturn_position #(
  parameter int unsigned COUNTS_PER_TURN = fpmp_pkg::COUNTS_PER_TURN_DEF,
  parameter int unsigned MAX_LAPS = fpmp_pkg::MAX_LAPS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [fpmp_pkg::CFG_AW-1:0] cfg_idx_i,
  input  logic [fpmp_pkg::CFG_DW-1:0] cfg_data_i,
  fpmp_in_if.sink                     in_ch,
  fpmp_out_if.source                  out_ch
);
  localparam logic signed [31:0] MAX32 = 32'sh7FFFFFFF;
  localparam logic signed [31:0] MIN32 = 32'sh80000000;

  logic [23:0] kp_q, ki_q, kd_q, din_q;
  logic [16:0] alpha_q, keep_q;
  logic [9:0]  whigh_q, wlow_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_q <= 24'd93716; ki_q <= 24'd5872; kd_q <= 24'd459;
      alpha_q <= 17'd32768; keep_q <= 17'd32768; din_q <= 24'd3276800;
      whigh_q <= 10'd25; wlow_q <= 10'd1;
    end else if (cfg_we_i) begin
      case (fpmp_pkg::reg_idx_e'(cfg_idx_i))
        fpmp_pkg::REG_PROP:  kp_q <= cfg_data_i;
        fpmp_pkg::REG_INTEG: ki_q <= cfg_data_i;
        fpmp_pkg::REG_DERIV: kd_q <= cfg_data_i;
        fpmp_pkg::REG_ALPHA: alpha_q <= cfg_data_i[16:0];
        fpmp_pkg::REG_KEEP:  keep_q <= cfg_data_i[16:0];
        fpmp_pkg::REG_DIN:   din_q <= cfg_data_i;
        fpmp_pkg::REG_WHIGH: whigh_q <= cfg_data_i[9:0];
        fpmp_pkg::REG_WLOW:  wlow_q <= cfg_data_i[9:0];
        default: ;
      endcase
    end
  end

  fpmp_pkg::state_e st_q, st_d;
  fpmp_pkg::wait_e  wait_q;
  logic signed [31:0] fe_q, de_q, is_q;
  logic signed [3:0]  lap_q;
  logic signed [8:0]  drv_q;
  logic start_q;
  logic signed [13:0] tgt_q;
  logic [9:0] pot_q;
  logic signed [16:0] err_q;   // raw error in counts
  logic signed [31:0] pfe_q;   // previous filtered error
  logic signed [32:0] dfe_q;   // fe - prev fe
  logic ovalid_q, osettled_q, ocross_q;
  logic signed [8:0] odrv_q;
  logic fin_q, fin_valid_q;

  // MAC operands
  logic mclr, men;
  logic signed [32:0] ma;
  logic signed [25:0] mb;
  logic signed [63:0] acc;
  fpmp_mac u_mac (.clk_i, .clr_i(mclr), .en_i(men), .a_i(ma), .b_i(mb), .acc_o(acc));

  logic [16:0] alpha_c, keep_c;
  assign alpha_c = (alpha_q > 17'd65536) ? 17'd65536 : alpha_q;
  assign keep_c  = (keep_q > 17'd65536) ? 17'd65536 : keep_q;

  function automatic logic signed [31:0] sat_round16(input logic signed [63:0] x);
    logic neg;
    logic [63:0] mag, r;
    logic signed [63:0] v;
    neg = x[63];
    mag = neg ? -x : x;
    r = (mag + 64'd32768) >> 16;
    v = neg ? -$signed(r) : $signed(r);
    if (v > 64'(MAX32)) return MAX32;
    if (v < 64'(MIN32)) return MIN32;
    return v[31:0];
  endfunction

  // position and error for current lap
  logic signed [17:0] pos_c;
  logic signed [17:0] err_c;
  assign pos_c = 18'(lap_q) * $signed(18'(COUNTS_PER_TURN)) + $signed({8'd0, pot_q});
  assign err_c = 18'(tgt_q) - pos_c;

  logic signed [31:0] fe_new, d_new;
  assign fe_new = sat_round16(acc);
  assign d_new = sat_round16(acc);

  logic signed [16:0] abs_err;
  assign abs_err = err_q[16] ? -err_q : err_q;
  logic integ_on;
  assign integ_on = (abs_err < $signed({7'd0, whigh_q})) && (abs_err > $signed({7'd0, wlow_q}));
  logic signed [32:0] is_sum;
  assign is_sum = 33'(is_q) + 33'(err_q) * 33'sd4096;

  logic signed [63:0] tr;
  logic [63:0] trmag;
  logic signed [36:0] drvw;
  assign trmag = (acc[63] ? -acc : acc) >> 28;
  assign drvw = acc[63] ? -$signed(trmag[36:0]) : $signed(trmag[36:0]);
  assign tr = 64'(drvw);

  // dead-zone evaluation for pos stage
  logic signed [17:0] up_lim, dn_lim;
  assign up_lim = (18'(lap_q) + 18'sd1) * $signed(18'(COUNTS_PER_TURN));
  assign dn_lim = 18'(lap_q) * $signed(18'(COUNTS_PER_TURN));

  assign in_ch.ready = (st_q == fpmp_pkg::ST_IDLE) && !ovalid_q && !fin_q && !fin_valid_q;

  always_comb begin
    st_d = st_q;
    case (st_q)
      fpmp_pkg::ST_IDLE: if (in_ch.valid && in_ch.ready) st_d = fpmp_pkg::ST_POS;
      fpmp_pkg::ST_POS:  st_d = fpmp_pkg::ST_FE1;
      fpmp_pkg::ST_FE1:  st_d = (wait_q != fpmp_pkg::WAIT_NONE) ? fpmp_pkg::ST_IDLE
                                : fpmp_pkg::ST_FE2;
      fpmp_pkg::ST_FE2:  st_d = fpmp_pkg::ST_FE3;
      fpmp_pkg::ST_FE3:  st_d = fpmp_pkg::ST_D1;
      fpmp_pkg::ST_D1:   st_d = fpmp_pkg::ST_D2;
      fpmp_pkg::ST_D2:   st_d = fpmp_pkg::ST_D3;
      fpmp_pkg::ST_D3:   st_d = fpmp_pkg::ST_P;
      fpmp_pkg::ST_P:    st_d = fpmp_pkg::ST_I;
      fpmp_pkg::ST_I:    st_d = fpmp_pkg::ST_DD;
      fpmp_pkg::ST_DD:   st_d = fpmp_pkg::ST_OUT;
      fpmp_pkg::ST_OUT:  st_d = fpmp_pkg::ST_IDLE;
      default:           st_d = fpmp_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    mclr = 1'b0; men = 1'b0; ma = '0; mb = '0;
    case (st_q)
      fpmp_pkg::ST_FE1: mclr = 1'b1;
      fpmp_pkg::ST_FE2: begin
        men = 1'b1; ma = 33'(err_q) * 33'sd4096; mb = $signed({9'd0, alpha_c});
      end
      fpmp_pkg::ST_FE3: begin
        men = 1'b1; ma = 33'(fe_q); mb = $signed(26'(18'd65536 - 18'(alpha_c)));
      end
      fpmp_pkg::ST_D1: mclr = 1'b1;
      fpmp_pkg::ST_D2: begin
        men = 1'b1; ma = dfe_q; mb = $signed({2'd0, din_q});
      end
      fpmp_pkg::ST_D3: begin
        men = 1'b1; ma = 33'(de_q); mb = $signed({9'd0, keep_c});
      end
      fpmp_pkg::ST_P: begin
        mclr = 1'b1;
      end
      fpmp_pkg::ST_I: begin
        men = 1'b1; ma = 33'(fe_q); mb = $signed({2'd0, kp_q});
      end
      fpmp_pkg::ST_DD: begin
        men = 1'b1; ma = 33'(is_q); mb = $signed({2'd0, ki_q});
      end
      fpmp_pkg::ST_OUT: begin
        men = 1'b1; ma = 33'(de_q); mb = $signed({2'd0, kd_q});
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= fpmp_pkg::ST_IDLE;
      wait_q <= fpmp_pkg::WAIT_NONE;
      fe_q <= '0; de_q <= '0; is_q <= '0; lap_q <= '0;
      ovalid_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (ovalid_q && out_ch.ready) ovalid_q <= 1'b0;
      case (st_q)
        fpmp_pkg::ST_IDLE: if (in_ch.valid && in_ch.ready) begin
          start_q <= in_ch.start_move;
          tgt_q <= in_ch.target;
          pot_q <= in_ch.pot_sample;
        end
        fpmp_pkg::ST_POS: begin
          if (start_q) begin
            fe_q <= 32'(err_c) * 32'sd4096;
            de_q <= '0;
          end
          case (wait_q)
            fpmp_pkg::WAIT_UP: if (pot_q <= 10'(fpmp_pkg::DEAD_LOW)) begin
              lap_q <= lap_q + 4'sd1; wait_q <= fpmp_pkg::WAIT_NONE;
            end
            fpmp_pkg::WAIT_DOWN: if (pot_q >= 10'(fpmp_pkg::DEAD_HIGH)) begin
              lap_q <= lap_q - 4'sd1; wait_q <= fpmp_pkg::WAIT_NONE;
            end
            default: begin
              if (pot_q > 10'(fpmp_pkg::DEAD_HIGH) && 18'(tgt_q) > up_lim &&
                  lap_q < $signed(4'(MAX_LAPS)))
                wait_q <= fpmp_pkg::WAIT_UP;
              else if (pot_q < 10'(fpmp_pkg::DEAD_LOW) && 18'(tgt_q) < dn_lim &&
                       lap_q > -$signed(4'(MAX_LAPS)))
                wait_q <= fpmp_pkg::WAIT_DOWN;
              else
                wait_q <= fpmp_pkg::WAIT_NONE;
            end
          endcase
        end
        fpmp_pkg::ST_FE1: begin
          err_q <= err_c[16:0];
          pfe_q <= fe_q;
          if (wait_q != fpmp_pkg::WAIT_NONE) begin
            ovalid_q <= 1'b1; odrv_q <= drv_q; osettled_q <= 1'b0; ocross_q <= 1'b1;
          end
        end
        fpmp_pkg::ST_D1: begin
          fe_q <= fe_new;
          dfe_q <= 33'(fe_new) - 33'(pfe_q);
        end
        fpmp_pkg::ST_P: begin
          de_q <= d_new;
          if (integ_on) begin
            if (is_sum > 33'(MAX32)) is_q <= MAX32;
            else if (is_sum < 33'(MIN32)) is_q <= MIN32;
            else is_q <= is_sum[31:0];
          end else is_q <= '0;
        end
        fpmp_pkg::ST_OUT: ;
        default: ;
      endcase
    end
  end

  // final drive formed the cycle after ST_OUT
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) fin_q <= 1'b0;
    else fin_q <= (st_q == fpmp_pkg::ST_OUT);
  end

  logic signed [8:0] drv_sat;
  assign drv_sat = (tr > 64'sd255) ? 9'sd255 : (tr < -64'sd255) ? -9'sd255 : tr[8:0];
  logic fe_small, d_small;
  assign fe_small = (fe_q > -32'sd8192) && (fe_q < 32'sd8192);
  assign d_small = (de_q > -32'sd20480) && (de_q < 32'sd20480);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fin_valid_q <= 1'b0;
    end else if (fin_q) begin
      fin_valid_q <= 1'b1;
    end else if (fin_valid_q && out_ch.ready) begin
      fin_valid_q <= 1'b0;
    end
  end
  logic signed [8:0] fdrv_q;
  logic fset_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) drv_q <= '0;
    else if (fin_q) drv_q <= drv_sat;
  end
  always_ff @(posedge clk_i) begin
    if (fin_q) begin
      fdrv_q <= drv_sat;
      fset_q <= fe_small && d_small;
    end
  end

  assign out_ch.valid = ovalid_q || fin_valid_q;
  assign out_ch.motor_drive = fin_valid_q ? fdrv_q : odrv_q;
  assign out_ch.settled = fin_valid_q ? fset_q : osettled_q;
  assign out_ch.crossing = fin_valid_q ? 1'b0 : ocross_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ovalid_q && fin_valid_q)) else $error("two results pending");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ch.ready |-> !out_ch.valid || ovalid_q) else $error("ready with pending result");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (lap_q <= $signed(4'(MAX_LAPS))) && (lap_q >= -$signed(4'(MAX_LAPS))))
    else $error("lap count out of range");
endmodule

// ===== sim/fpmp_checker.sv =====
`timescale 1ns / 1ps
// Checker for the multi-turn position controller: watches the tick, result and
// register write ports, predicts each result and compares. Depends on fpmp_pkg and fpmp_if.
module fpmp_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [fpmp_pkg::CFG_AW-1:0] cfg_idx_i,
  input  logic [fpmp_pkg::CFG_DW-1:0] cfg_data_i,
  fpmp_in_if                          in_ch,
  fpmp_out_if                         out_ch,
  output int                          fail_count_o,
  output int                          pending_o
);
  localparam longint TURN = fpmp_pkg::COUNTS_PER_TURN_DEF;
  localparam int LAPS = fpmp_pkg::MAX_LAPS_DEF;
  localparam longint ONE = 65536;
  localparam longint DHIGH = fpmp_pkg::DEAD_HIGH;
  localparam longint DLOW = fpmp_pkg::DEAD_LOW;

  typedef struct packed {
    logic signed [8:0] drive;
    logic              settled;
    logic              crossing;
  } drive_res_t;

  drive_res_t expected_q[$];

  logic [23:0] kp, ki, kd, din;
  logic [16:0] alpha, keep;
  logic [9:0]  win_hi, win_lo;

  longint filt_err, deriv_est, integ_sum;
  int      laps;
  fpmp_pkg::wait_e wmode;
  logic signed [8:0] held_drive;

  int fails;
  assign fail_count_o = fails;
  assign pending_o = expected_q.size();

  function automatic longint sat32(longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  function automatic longint round_shift(longint x, int k);
    longint mag;
    mag = (x < 0) ? -x : x;
    mag = (mag + (64'sd1 <<< (k - 1))) >>> k;
    return (x < 0) ? -mag : mag;
  endfunction

  function automatic longint trunc_shift(longint x, int k);
    longint mag;
    mag = (x < 0) ? -x : x;
    mag = mag >>> k;
    return (x < 0) ? -mag : mag;
  endfunction

  function automatic longint absl(longint x);
    return (x < 0) ? -x : x;
  endfunction

  function automatic drive_res_t step_controller(logic start, logic signed [13:0] tgt,
                                                 logic [9:0] pot);
    drive_res_t r;
    longint t, p, err, a, kk, prev, fe, d, ae, acc, drv;
    t = longint'(tgt);
    p = longint'(pot);
    if (start) begin
      filt_err = sat32((t - (longint'(laps) * TURN + p)) * 4096);
      deriv_est = 0;
    end
    if (wmode == fpmp_pkg::WAIT_UP) begin
      if (p <= DLOW) begin
        laps++;
        wmode = fpmp_pkg::WAIT_NONE;
      end
    end else if (wmode == fpmp_pkg::WAIT_DOWN) begin
      if (p >= DHIGH) begin
        laps--;
        wmode = fpmp_pkg::WAIT_NONE;
      end
    end else begin
      wmode = fpmp_pkg::WAIT_NONE;
      if (p > DHIGH) begin
        if (t > TURN * (laps + 1) && laps < LAPS) wmode = fpmp_pkg::WAIT_UP;
      end else if (p < DLOW) begin
        if (t < TURN * laps && laps > -LAPS) wmode = fpmp_pkg::WAIT_DOWN;
      end
    end
    if (wmode != fpmp_pkg::WAIT_NONE) begin
      r.drive = held_drive;
      r.settled = 1'b0;
      r.crossing = 1'b1;
      return r;
    end
    err = t - (longint'(laps) * TURN + p);
    a = (alpha > ONE) ? ONE : longint'(alpha);
    kk = (keep > ONE) ? ONE : longint'(keep);
    prev = filt_err;
    fe = sat32(round_shift(a * (err * 4096) + (ONE - a) * prev, 16));
    filt_err = fe;
    d = sat32(round_shift(longint'(din) * (fe - prev) + kk * deriv_est, 16));
    deriv_est = d;
    ae = absl(err);
    if (ae < longint'(win_hi) && ae > longint'(win_lo)) integ_sum = sat32(integ_sum + err * 4096);
    else integ_sum = 0;
    acc = longint'(kp) * fe + longint'(ki) * integ_sum + longint'(kd) * d;
    drv = trunc_shift(acc, 28);
    if (drv > 255) drv = 255;
    if (drv < -255) drv = -255;
    held_drive = drv[8:0];
    r.drive = drv[8:0];
    r.settled = (absl(fe) < 2 * 4096 && absl(d) < 5 * 4096);
    r.crossing = 1'b0;
    return r;
  endfunction

  task automatic report_mismatch(string what);
    $display("%0t mismatch: %s", $time, what);
    fails++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    drive_res_t exp_r;
    if (!rst_ni) begin
      kp <= 24'd93716; ki <= 24'd5872; kd <= 24'd459;
      alpha <= 17'd32768; keep <= 17'd32768; din <= 24'd3276800;
      win_hi <= 10'd25; win_lo <= 10'd1;
      filt_err = 0; deriv_est = 0; integ_sum = 0;
      laps = 0; wmode = fpmp_pkg::WAIT_NONE; held_drive = '0;
      expected_q.delete();
      fails = 0;
    end else begin
      if (cfg_we_i) begin
        case (fpmp_pkg::reg_idx_e'(cfg_idx_i))
          fpmp_pkg::REG_PROP:  kp <= cfg_data_i;
          fpmp_pkg::REG_INTEG: ki <= cfg_data_i;
          fpmp_pkg::REG_DERIV: kd <= cfg_data_i;
          fpmp_pkg::REG_ALPHA: alpha <= cfg_data_i[16:0];
          fpmp_pkg::REG_KEEP:  keep <= cfg_data_i[16:0];
          fpmp_pkg::REG_DIN:   din <= cfg_data_i;
          fpmp_pkg::REG_WHIGH: win_hi <= cfg_data_i[9:0];
          fpmp_pkg::REG_WLOW:  win_lo <= cfg_data_i[9:0];
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready)
        expected_q.push_back(step_controller(in_ch.start_move, in_ch.target, in_ch.pot_sample));
      if (out_ch.valid && out_ch.ready) begin
        if (expected_q.size() == 0) begin
          report_mismatch("result with no tick pending");
        end else begin
          exp_r = expected_q.pop_front();
          if (out_ch.motor_drive !== exp_r.drive)
            report_mismatch($sformatf("motor_drive %0d, want %0d", out_ch.motor_drive,
                                      exp_r.drive));
          if (out_ch.settled !== exp_r.settled)
            report_mismatch($sformatf("settled %b, want %b", out_ch.settled, exp_r.settled));
          if (out_ch.crossing !== exp_r.crossing)
            report_mismatch($sformatf("crossing %b, want %b", out_ch.crossing,
                                      exp_r.crossing));
        end
      end
    end
  end
endmodule

// ===== sim/tb_filtered_pid_multiturn_position.sv =====
`timescale 1ns / 1ps
// Testbench top for the multi-turn position controller: clock, reset, stimulus
// and verdict. Depends on fpmp_pkg, fpmp_if and fpmp_checker.
module tb_filtered_pid_multiturn_position;
  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [fpmp_pkg::CFG_AW-1:0] cfg_idx_i;
  logic [fpmp_pkg::CFG_DW-1:0] cfg_data_i;
  int fail_count, pending;
  bit no_idle;

  fpmp_in_if  in_ch ();
  fpmp_out_if out_ch ();

  filtered_pid_multiturn_position dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i, .in_ch, .out_ch
  );

  fpmp_checker chk (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i, .in_ch, .out_ch,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // result side stalls
  initial begin
    int g;
    out_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      out_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 20)) @(posedge clk_i);
      g = pick_gap();
      if (g > 0) begin
        out_ch.ready <= 1'b0;
        repeat (g - 1) @(posedge clk_i);
      end
    end
  end

  task automatic send_tick(logic s, logic signed [13:0] t, logic [9:0] p);
    int g;
    in_ch.valid <= 1'b1;
    in_ch.start_move <= s;
    in_ch.target <= t;
    in_ch.pot_sample <= p;
    do @(posedge clk_i); while (!in_ch.ready);
    g = pick_gap();
    if (g > 0) begin
      in_ch.valid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_reg(fpmp_pkg::reg_idx_e idx, logic [fpmp_pkg::CFG_DW-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic load_gains(int mode);
    if (mode == 0) begin
      write_reg(fpmp_pkg::REG_PROP, 24'hFFFFFF); write_reg(fpmp_pkg::REG_INTEG, 24'hFFFFFF);
      write_reg(fpmp_pkg::REG_DERIV, 24'hFFFFFF); write_reg(fpmp_pkg::REG_ALPHA, 24'h1FFFF);
      write_reg(fpmp_pkg::REG_KEEP, 24'h1FFFF); write_reg(fpmp_pkg::REG_DIN, 24'hFFFFFF);
      write_reg(fpmp_pkg::REG_WHIGH, 24'h3FF); write_reg(fpmp_pkg::REG_WLOW, 24'h0);
    end else if (mode == 1) begin
      write_reg(fpmp_pkg::REG_PROP, 24'h0); write_reg(fpmp_pkg::REG_INTEG, 24'h0);
      write_reg(fpmp_pkg::REG_DERIV, 24'h0); write_reg(fpmp_pkg::REG_ALPHA, 24'h0);
      write_reg(fpmp_pkg::REG_KEEP, 24'h0); write_reg(fpmp_pkg::REG_DIN, 24'h0);
      write_reg(fpmp_pkg::REG_WHIGH, 24'h0); write_reg(fpmp_pkg::REG_WLOW, 24'h3FF);
    end else begin
      write_reg(fpmp_pkg::REG_PROP, 24'($urandom_range(0, 24'hFFFFFF)));
      write_reg(fpmp_pkg::REG_INTEG, 24'($urandom_range(0, 24'h3FFFF)));
      write_reg(fpmp_pkg::REG_DERIV, 24'($urandom_range(0, 24'hFFFFFF)));
      write_reg(fpmp_pkg::REG_ALPHA, 24'($urandom_range(0, 24'h1FFFF)));
      write_reg(fpmp_pkg::REG_KEEP, 24'($urandom_range(0, 24'h1FFFF)));
      write_reg(fpmp_pkg::REG_DIN, 24'($urandom_range(0, 24'hFFFFFF)));
      write_reg(fpmp_pkg::REG_WHIGH, 24'($urandom_range(0, 1023)));
      write_reg(fpmp_pkg::REG_WLOW, 24'($urandom_range(0, 40)));
    end
  endtask

  // one well-formed sweep: the pot walks in one direction and wraps through
  // the dead zone while the target lies outside the starting turn
  task automatic run_sweep();
    int pos, n, up, st;
    logic signed [13:0] t;
    up = $urandom_range(0, 1);
    pos = $urandom_range(0, 1023);
    t = up ? 14'($urandom_range(1500, 8191)) : -14'($urandom_range(500, 8192));
    n = $urandom_range(20, 60);
    for (int i = 0; i < n; i++) begin
      st = ((pos > 990 || pos < 30) ? $urandom_range(1, 6) : $urandom_range(1, 40));
      pos = up ? pos + st : pos - st;
      if (pos > 1023) pos -= 1024;
      if (pos < 0) pos += 1024;
      send_tick(i == 0 || $urandom_range(0, 30) == 0, t, 10'(pos));
    end
  endtask

  initial begin
    int nitems;
    in_ch.valid = 1'b0;
    in_ch.start_move = 1'b0;
    in_ch.target = '0;
    in_ch.pot_sample = '0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    no_idle = 1'b0;
    rst_ni = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset gains, extremes, crossings up and down
    send_tick(1'b1, 14'sd8191, 10'd0);
    send_tick(1'b0, -14'sd8192, 10'd1023);
    send_tick(1'b1, 14'sd500, 10'd500);
    send_tick(1'b0, 14'sd510, 10'd500);
    send_tick(1'b0, 14'sd525, 10'd500);
    send_tick(1'b0, 14'sd501, 10'd500);
    send_tick(1'b1, 14'sd2000, 10'd1018);
    send_tick(1'b0, 14'sd2000, 10'd1019);
    send_tick(1'b0, 14'sd2000, 10'd6);
    send_tick(1'b1, 14'sd3000, 10'd900);
    send_tick(1'b0, 14'sd2000, 10'd5);
    send_tick(1'b1, 14'sd3000, 10'd1020);
    send_tick(1'b1, 14'sd3100, 10'd1023);
    send_tick(1'b0, 14'sd3100, 10'd2);
    send_tick(1'b0, -14'sd100, 10'd4);
    send_tick(1'b0, -14'sd100, 10'd1017);
    send_tick(1'b0, -14'sd100, 10'd1018);
    send_tick(1'b0, -14'sd100, 10'd5);
    send_tick(1'b0, -14'sd8192, 10'd0);
    send_tick(1'b0, 14'sd0, 10'd1023);
    drain();

    for (int ph = 0; ph < 12; ph++) begin
      load_gains(ph < 2 ? ph : 2);
      no_idle = (ph % 4 == 3);
      nitems = 0;
      while (nitems < 140) begin
        if ($urandom_range(0, 9) < 7) begin
          run_sweep();
          nitems += 40;
        end else begin
          for (int i = 0; i < 10; i++)
            send_tick(1'($urandom), 14'($urandom), 10'($urandom));
          nitems += 10;
        end
      end
      drain();
    end

    if (fail_count == 0 && pending == 0) $display("tb_filtered_pid_multiturn_position: done, clean");
    else $display("tb_filtered_pid_multiturn_position: done, errors");
    $finish;
  end

  initial begin
    #20ms;
    $display("tb_filtered_pid_multiturn_position: done, errors");
    $finish;
  end
endmodule
